// ===== rtl/tcl_pkg.sv =====
// Shared types, widths and codes for the tile cache eviction block.
// Used by tcl_csr and the top level; depends on nothing else.
package tcl_pkg;

   // Default table depth; the top level hands it down as a parameter.
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Fixed field widths.
   localparam int COORD_W  = 32;
   localparam int STAMP_W  = 32;
   localparam int ENTRY_W  = 2 * COORD_W + STAMP_W;
   localparam int LIVE_W   = 7;
   localparam int NUM_W    = 42;
   localparam int DEN_W    = 45;
   localparam int BOUND_W  = 44;

   // Request opcodes.
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_TOUCH = 2'd0;
   localparam opcode_type OP_DROP  = 2'd1;
   localparam opcode_type OP_EVICT = 2'd2;

   // Configuration register indexes.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_TILE_SIZE = 3'd0;
   localparam csr_index_type CSR_PAN_H     = 3'd1;
   localparam csr_index_type CSR_PAN_V     = 3'd2;
   localparam csr_index_type CSR_ZOOM      = 3'd3;
   localparam csr_index_type CSR_SCREEN_W  = 3'd4;
   localparam csr_index_type CSR_SCREEN_H  = 3'd5;

   // Effective view configuration, with tile size and zoom already clamped.
   typedef struct packed {
      logic [12:0]        tile_size;
      logic signed [31:0] pan_h;
      logic signed [31:0] pan_v;
      logic [31:0]        zoom;
      logic [15:0]        screen_w;
      logic [15:0]        screen_h;
   } cfg_type;

   // Controller states.
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SRCH = 7'b0000010,
      S_UPD  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_MARK = 7'b0100000,
      S_PICK = 7'b1000000
   } state_type;

endpackage

// ===== rtl/tcl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module tcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/tcl_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the top level for the view window bounds.
module tcl_div #(
   parameter int NW = 42,
   parameter int DW = 45
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient,
   output logic          rem_nz
);

   localparam int CNTW = $clog2(NW + 1);

   logic          run_ff, run_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] shift_ff, shift_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          q_bit;

   // One shift-and-subtract step.
   always_comb begin
      trial    = {rem_ff, shift_ff[NW-1]};
      q_bit    = trial >= {1'b0, dsr_ff};
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      done_in  = 1'b0;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (run_ff) begin
         rem_in   = q_bit ? DW'(trial - {1'b0, dsr_ff}) : DW'(trial);
         shift_in = {shift_ff[NW-2:0], q_bit};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;
   assign rem_nz   = rem_ff != '0;

endmodule

// ===== rtl/tcl_csr.sv =====
// Configuration registers of the view window, with tile size and zoom clamping.
// Depends on tcl_pkg.
module tcl_csr
   import tcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data,
   output cfg_type       cfg
);

   logic [12:0] tile_ff;
   logic [31:0] pan_h_ff;
   logic [31:0] pan_v_ff;
   logic [31:0] zoom_ff;
   logic [15:0] sw_ff;
   logic [15:0] sh_ff;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_ff  <= 13'd256;
         pan_h_ff <= '0;
         pan_v_ff <= '0;
         zoom_ff  <= 32'd65536;
         sw_ff    <= '0;
         sh_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TILE_SIZE: tile_ff  <= csr_data[12:0];
            CSR_PAN_H:     pan_h_ff <= csr_data;
            CSR_PAN_V:     pan_v_ff <= csr_data;
            CSR_ZOOM:      zoom_ff  <= csr_data;
            CSR_SCREEN_W:  sw_ff    <= csr_data[15:0];
            CSR_SCREEN_H:  sh_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Tiles below eight pixels act as eight, and a zero zoom acts as one.
   always_comb begin
      cfg.tile_size = (tile_ff < 13'd8) ? 13'd8 : tile_ff;
      cfg.pan_h     = $signed(pan_h_ff);
      cfg.pan_v     = $signed(pan_v_ff);
      cfg.zoom      = (zoom_ff == '0) ? 32'd1 : zoom_ff;
      cfg.screen_w  = sw_ff;
      cfg.screen_h  = sh_ff;
   end

endmodule

// ===== rtl/tile_cache_lru_eviction.sv =====
// Tile cache with LRU eviction outside a pinned view window.
// Touch and drop make one pass over the entry RAM, then an update.
// Eviction runs the window divider, then a marking pass and one more pass per result,
// one RAM read a cycle. One item at a time; each result is a one-cycle strobe.
// Synchronous reset empties the table through its valid bits and restores the default
// view configuration.
module tile_cache_lru_eviction
   import tcl_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic signed [COORD_W-1:0] req_tile_col,
   input  logic signed [COORD_W-1:0] req_tile_row,
   input  logic [STAMP_W-1:0]        req_use_stamp,
   input  logic [15:0]               req_keep_budget,
   input  logic [15:0]               req_ring_width,
   output logic                      rsp_strobe,
   output logic                      rsp_has_tile,
   output logic signed [COORD_W-1:0] rsp_out_col,
   output logic signed [COORD_W-1:0] rsp_out_row,
   output logic                      rsp_last,
   output logic                      rsp_status,
   output logic [LIVE_W-1:0]         rsp_live_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   cfg_type cfg;

   // Controller registers.
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] cand_ff, cand_in;
   logic [CW-1:0] cand_cnt_ff, cand_cnt_in;
   logic [CW-1:0] over_ff, over_in;
   logic [CW-1:0] emitted_ff, emitted_in;

   // Scan pipeline over the entry RAM.
   logic [CW-1:0] scan_ff, scan_in;
   logic          pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0] pipe_idx_ff, pipe_idx_in;

   // Latched request.
   opcode_type         op_ff, op_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [15:0]        budget_ff, budget_in;
   logic [15:0]        ring_ff, ring_in;

   // Search results.
   logic          match_ff, match_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;

   // Oldest candidate of the current pass.
   logic               best_ff, best_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [COORD_W-1:0] best_col_ff, best_col_in;
   logic [COORD_W-1:0] best_row_ff, best_row_in;

   // Window arithmetic.
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [1:0]                sel_ff, sel_in;
   logic                      div_start_ff, div_start_in;
   logic signed [BOUND_W-1:0] vx0_ff, vx0_in, vx1_ff, vx1_in;
   logic signed [BOUND_W-1:0] vy0_ff, vy0_in, vy1_ff, vy1_in;

   // Result registers.
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_has_ff, rsp_has_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [LIVE_W-1:0]  rsp_live_ff, rsp_live_in;

   // RAM and divider wiring.
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [COORD_W-1:0] rd_col, rd_row;
   logic [STAMP_W-1:0] rd_stamp;
   logic               div_done;
   logic [NUM_W-1:0]   div_q;
   logic               div_rnz;

   // Combinational helpers.
   logic                      scan_active, scan_issue, scan_end;
   logic [15:0]               scr;
   logic [31:0]               pan;
   logic [33:0]               diff;
   logic [NUM_W-1:0]          num, num_mag;
   logic                      num_neg;
   logic signed [BOUND_W-1:0] q_ext, fq, ring_ext, bound;
   logic signed [BOUND_W-1:0] c_ext, r_ext;
   logic                      in_window, older;

   tcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tcl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   tcl_div #(
      .NW (NUM_W),
      .DW (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (num_mag),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rnz)
   );

   assign rd_col   = rd_data[ENTRY_W-1 -: COORD_W];
   assign rd_row   = rd_data[STAMP_W +: COORD_W];
   assign rd_stamp = rd_data[STAMP_W-1:0];

   // Numerator of the window bound being divided: (s*256 - pan) * 256.
   always_comb begin
      scr      = sel_ff[1] ? (sel_ff[0] ? cfg.screen_h : cfg.screen_w) : 16'd0;
      pan      = sel_ff[0] ? cfg.pan_v : cfg.pan_h;
      diff     = {10'd0, scr, 8'd0} - {{2{pan[31]}}, pan};
      num      = {diff, 8'd0};
      num_neg  = num[NUM_W-1];
      num_mag  = num_neg ? (NUM_W'(0) - num) : num;
      q_ext    = $signed({{(BOUND_W-NUM_W){1'b0}}, div_q});
      fq       = num_neg ? (BOUND_W'(0) - q_ext - BOUND_W'(div_rnz)) : q_ext;
      ring_ext = $signed({{(BOUND_W-16){1'b0}}, ring_ff});
      bound    = sel_ff[1] ? (fq + ring_ext) : (fq - ring_ext);
   end

   // Window test and eviction order for the entry on the read port.
   always_comb begin
      c_ext     = $signed({{(BOUND_W-COORD_W){rd_col[COORD_W-1]}}, rd_col});
      r_ext     = $signed({{(BOUND_W-COORD_W){rd_row[COORD_W-1]}}, rd_row});
      in_window = (c_ext >= vx0_ff) && (c_ext <= vx1_ff)
                  && (r_ext >= vy0_ff) && (r_ext <= vy1_ff);
      if (rd_stamp != best_stamp_ff) begin
         older = rd_stamp < best_stamp_ff;
      end else if (rd_col != best_col_ff) begin
         older = $signed(rd_col) < $signed(best_col_ff);
      end else begin
         older = rd_row < best_row_ff;
      end
   end

   // Scan sequencing: one address issued per cycle, its data processed in the following cycle.
   assign scan_active = (state_ff == S_SRCH) || (state_ff == S_MARK) || (state_ff == S_PICK);
   assign scan_issue  = scan_ff < CW'(TABLE_DEPTH);
   assign scan_end    = !scan_issue && !pipe_vld_ff;
   assign rd_en       = scan_active && scan_issue;

   // Next-state logic of the controller.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      cand_in       = cand_ff;
      cand_cnt_in   = cand_cnt_ff;
      over_in       = over_ff;
      emitted_in    = emitted_ff;
      scan_in       = scan_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = scan_ff[AW-1:0];
      op_in         = op_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      stamp_in      = stamp_ff;
      budget_in     = budget_ff;
      ring_in       = ring_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_col_in   = best_col_ff;
      best_row_in   = best_row_ff;
      den_in        = den_ff;
      sel_in        = sel_ff;
      div_start_in  = 1'b0;
      vx0_in        = vx0_ff;
      vx1_in        = vx1_ff;
      vy0_in        = vy0_ff;
      vy1_in        = vy1_ff;
      rsp_strobe_in = 1'b0;
      rsp_has_in    = 1'b0;
      rsp_col_in    = '0;
      rsp_row_in    = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = 1'b0;
      rsp_live_in   = LIVE_W'(count_ff);
      wr_en         = 1'b0;
      wr_addr       = match_idx_ff;
      wr_data       = {col_ff, row_ff, stamp_ff};

      if (scan_active && scan_issue) begin
         scan_in     = scan_ff + 1'b1;
         pipe_vld_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               op_in     = req_opcode;
               col_in    = req_tile_col;
               row_in    = req_tile_row;
               stamp_in  = req_use_stamp;
               budget_in = req_keep_budget;
               ring_in   = req_ring_width;
               unique case (req_opcode) inside
                  OP_TOUCH, OP_DROP: begin
                     state_in = S_SRCH;
                     scan_in  = '0;
                     match_in = 1'b0;
                     free_in  = 1'b0;
                  end
                  OP_EVICT: begin
                     if (16'(count_ff) > req_keep_budget) begin
                        state_in = S_MUL;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end

         // Look for the tile and for the lowest free slot.
         S_SRCH: begin
            if (pipe_vld_ff) begin
               if (valid_ff[pipe_idx_ff] && rd_col == col_ff && rd_row == row_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = pipe_idx_ff;
               end
               if (!valid_ff[pipe_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
            end
            if (scan_end) begin
               state_in = S_UPD;
            end
         end

         // Write back the touched entry or clear the dropped entry's valid bit, and report.
         S_UPD: begin
            if (op_ff == OP_TOUCH) begin
               if (match_ff) begin
                  wr_en = 1'b1;
               end else if (free_ff) begin
                  wr_en                 = 1'b1;
                  wr_addr               = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + 1'b1;
               end else begin
                  rsp_status_in = 1'b1;
               end
            end else if (match_ff) begin
               valid_in[match_idx_ff] = 1'b0;
               count_in               = count_ff - 1'b1;
            end
            rsp_strobe_in = 1'b1;
            rsp_live_in   = LIVE_W'(count_in);
            state_in      = S_IDLE;
         end

         // Divisor of the window bounds: zoom times tile size.
         S_MUL: begin
            den_in       = DEN_W'(cfg.zoom) * DEN_W'(cfg.tile_size);
            sel_in       = 2'd0;
            div_start_in = 1'b1;
            state_in     = S_DIV;
         end

         // Four floor divisions: left, top, right, bottom.
         S_DIV: begin
            if (div_done) begin
               case (sel_ff)
                  2'd0:    vx0_in = bound;
                  2'd1:    vy0_in = bound;
                  2'd2:    vx1_in = bound;
                  default: vy1_in = bound;
               endcase
               if (sel_ff == 2'd3) begin
                  state_in    = S_MARK;
                  scan_in     = '0;
                  cand_cnt_in = '0;
               end else begin
                  sel_in       = sel_ff + 1'b1;
                  div_start_in = 1'b1;
               end
            end
         end

         // Mark live tiles outside the window as candidates.
         S_MARK: begin
            if (pipe_vld_ff) begin
               cand_in[pipe_idx_ff] = valid_ff[pipe_idx_ff] && !in_window;
               if (valid_ff[pipe_idx_ff] && !in_window) begin
                  cand_cnt_in = cand_cnt_ff + 1'b1;
               end
            end
            if (scan_end) begin
               if (cand_cnt_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  over_in    = CW'(17'(count_ff) - {1'b0, budget_ff});
                  emitted_in = '0;
                  best_in    = 1'b0;
                  scan_in    = '0;
                  state_in   = S_PICK;
               end
            end
         end

         // One pass per result: pick the oldest remaining candidate.
         S_PICK: begin
            if (pipe_vld_ff && cand_ff[pipe_idx_ff] && (!best_ff || older)) begin
               best_in       = 1'b1;
               best_idx_in   = pipe_idx_ff;
               best_stamp_in = rd_stamp;
               best_col_in   = rd_col;
               best_row_in   = rd_row;
            end
            if (scan_end) begin
               cand_in[best_idx_ff] = 1'b0;
               cand_cnt_in          = cand_cnt_ff - 1'b1;
               emitted_in           = emitted_ff + 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_has_in           = 1'b1;
               rsp_col_in           = best_col_ff;
               rsp_row_in           = best_row_ff;
               rsp_last_in          = (emitted_in == over_ff) || (cand_cnt_ff == CW'(1));
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  best_in = 1'b0;
                  scan_in = '0;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         valid_ff      <= '0;
         pipe_vld_ff   <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         pipe_vld_ff   <= pipe_vld_in;
         div_start_ff  <= div_start_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cand_ff       <= cand_in;
      cand_cnt_ff   <= cand_cnt_in;
      over_ff       <= over_in;
      emitted_ff    <= emitted_in;
      scan_ff       <= scan_in;
      pipe_idx_ff   <= pipe_idx_in;
      op_ff         <= op_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      stamp_ff      <= stamp_in;
      budget_ff     <= budget_in;
      ring_ff       <= ring_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_col_ff   <= best_col_in;
      best_row_ff   <= best_row_in;
      den_ff        <= den_in;
      sel_ff        <= sel_in;
      vx0_ff        <= vx0_in;
      vx1_ff        <= vx1_in;
      vy0_ff        <= vy0_in;
      vy1_ff        <= vy1_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_has_tile   = rsp_has_ff;
   assign rsp_out_col    = $signed(rsp_col_ff);
   assign rsp_out_row    = $signed(rsp_row_ff);
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule
